@@ src/hgp_pkg.sv @@
// Package for the hex grid pixel-to-cell block: types, register codes and
// the one-bit divider step that the pipeline stages share.
// Used by hgp_geom and hex_grid_pixel_to_cell.
`timescale 1ns / 1ps
`default_nettype none
package hgp_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 10;
    localparam int DIV_BITS = 14;   // local coordinates inside the map fit 14 bits

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TILE_W  = 3'd0,
        CFG_TILE_H  = 3'd1,
        CFG_SIDE    = 3'd2,
        CFG_GRID_W  = 3'd3,
        CFG_GRID_H  = 3'd4,
        CFG_LEFT    = 3'd5,
        CFG_TOP     = 3'd6,
        CFG_UNUSED  = 3'd7
    } t_cfg_idx;

    localparam logic [6:0] RST_TILE_W = 7'd41;
    localparam logic [6:0] RST_TILE_H = 7'd41;
    localparam logic [6:0] RST_SIDE   = 7'd21;
    localparam logic [6:0] RST_GRID_W = 7'd1;
    localparam logic [6:0] RST_GRID_H = 7'd1;
    localparam logic [9:0] RST_LEFT   = 10'd1;
    localparam logic [9:0] RST_TOP    = 10'd1;

    // Parities of half column (bit 0) and row (bit 1) in the sloped band.
    typedef enum logic [1:0] {
        PAR_XE_YE = 2'b00,
        PAR_XO_YE = 2'b01,
        PAR_XE_YO = 2'b10,
        PAR_XO_YO = 2'b11
    } t_par;

    typedef struct packed {
        logic              ok;       // geometry usable and grid not empty
        logic [6:0]        half;
        logic [6:0]        hstep;
        logic [6:0]        rowstep;
        logic [6:0]        slope;    // zero when the edge slope is not positive
        logic [11:0]       ta;       // slope * half
        logic [9:0]        left;
        logic [9:0]        top;
        logic [15:0]       x_end;    // left + map width
        logic [15:0]       y_end;    // top + map height
        logic [6:0]        gw;
        logic [6:0]        gh;
    } t_geom;

    typedef struct packed {
        logic [6:0]          rem;
        logic [DIV_BITS-1:0] quo;    // holds the dividend, shifted out as quotient bits enter
    } t_div;

    typedef struct packed {
        logic signed [15:0]  raw_x;
        logic signed [15:0]  raw_y;
        logic                inmap;
        logic [DIV_BITS-1:0] lx;
        logic [DIV_BITS-1:0] ly;
        t_div                dy;     // ly / rowstep
        t_div                dh;     // lx / half
        t_div                df0;    // lx / hstep
        t_div                df1;    // (lx - half) / hstep, clamped at zero
        logic                sloped;
        logic                lt_a;
        logic                lt_b;
    } t_item;

    typedef struct packed {
        logic               hit;
        logic signed [7:0]  hex_col;
        logic signed [7:0]  hex_row;
        logic signed [15:0] local_x;
        logic signed [15:0] local_y;
    } t_res;

    // One restoring step: bring in the next dividend bit, subtract if it fits.
    function automatic t_div div_step(input t_div cur, input logic [6:0] d);
        logic [7:0] t;
        t_div       nx;
        t = {cur.rem, cur.quo[DIV_BITS-1]};
        nx.quo = {cur.quo[DIV_BITS-2:0], 1'b0};
        if (t >= {1'b0, d}) begin
            t = t - {1'b0, d};
            nx.quo[0] = 1'b1;
        end
        nx.rem = t[6:0];
        return nx;
    endfunction

endpackage
`default_nettype wire

@@ src/hgp_px_if.sv @@
// Channel carrying one pixel query.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface hgp_px_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] pixel_x;
    logic signed [15:0] pixel_y;
    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface
`default_nettype wire

@@ src/hgp_res_if.sv @@
// Channel carrying one cell lookup result.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface hgp_res_if;
    logic               valid;
    logic               ready;
    logic               hit;
    logic signed [7:0]  hex_col;
    logic signed [7:0]  hex_row;
    logic signed [15:0] local_x;
    logic signed [15:0] local_y;
    modport source (output valid, output hit, output hex_col, output hex_row,
                    output local_x, output local_y, input ready);
    modport sink (input valid, input hit, input hex_col, input hex_row,
                  input local_x, input local_y, output ready);
endinterface
`default_nettype wire

@@ src/hgp_geom.sv @@
// Configuration registers and the grid step sizes derived from them.
// Depends on hgp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hgp_geom (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [hgp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [hgp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output hgp_pkg::t_geom                     o_geom
);
    import hgp_pkg::*;

    logic [6:0] r_tile_w, r_tile_h, r_side, r_grid_w, r_grid_h;
    logic [9:0] r_left, r_top;
    t_geom      r_geom, n_geom;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tile_w <= RST_TILE_W;
            r_tile_h <= RST_TILE_H;
            r_side   <= RST_SIDE;
            r_grid_w <= RST_GRID_W;
            r_grid_h <= RST_GRID_H;
            r_left   <= RST_LEFT;
            r_top    <= RST_TOP;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_TILE_W: r_tile_w <= i_cfg_data[6:0];
                CFG_TILE_H: r_tile_h <= i_cfg_data[6:0];
                CFG_SIDE:   r_side   <= i_cfg_data[6:0];
                CFG_GRID_W: r_grid_w <= i_cfg_data[6:0];
                CFG_GRID_H: r_grid_h <= i_cfg_data[6:0];
                CFG_LEFT:   r_left   <= i_cfg_data;
                CFG_TOP:    r_top    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic signed [7:0]  diff;
    logic signed [7:0]  slope;
    logic signed [8:0]  rowstep;
    logic [6:0]         half, hstep, gw_m1, gh_m1;
    logic [13:0]        mw_mul, mh_mul;
    logic [9:0]         left, top;

    always_comb begin
        diff    = $signed({1'b0, r_tile_h}) - $signed({1'b0, r_side});
        // Halve with truncation toward zero.
        slope   = diff[7] ? -((-diff) >>> 1) : (diff >>> 1);
        rowstep = 9'(slope) + $signed({2'b00, 7'(r_tile_h - 7'd1) >> 1}) - 9'sd1;
        hstep   = r_tile_w - 7'd1;
        half    = hstep >> 1;
        gw_m1   = r_grid_w - 7'd1;
        gh_m1   = r_grid_h - 7'd1;
        mw_mul  = gw_m1 * hstep;
        mh_mul  = gh_m1 * rowstep[6:0];
        left    = (r_left == 10'd0) ? 10'd1 : r_left;
        top     = (r_top == 10'd0) ? 10'd1 : r_top;

        n_geom.ok      = (r_grid_w != 7'd0) && (r_grid_h != 7'd0) && (r_tile_w >= 7'd3)
                         && (rowstep > 9'sd0);
        n_geom.half    = half;
        n_geom.hstep   = hstep;
        n_geom.rowstep = rowstep[6:0];
        n_geom.slope   = (slope > 8'sd0) ? slope[6:0] : 7'd0;
        n_geom.ta      = 12'({5'd0, n_geom.slope} * {5'd0, half});
        n_geom.left    = left;
        n_geom.top     = top;
        n_geom.x_end   = 16'(left) + 16'(r_tile_w) + 16'(mw_mul) + 16'(half);
        n_geom.y_end   = 16'(top) + 16'(r_tile_h) + 16'(mh_mul);
        n_geom.gw      = r_grid_w;
        n_geom.gh      = r_grid_h;
    end

    always_ff @(posedge i_clk) begin
        r_geom <= n_geom;
    end

    assign o_geom = r_geom;

endmodule
`default_nettype wire

@@ src/hex_grid_pixel_to_cell.sv @@
// Top level: pixel to pointy-top hex cell lookup, a 17-stage pipeline.
// Depends on hgp_pkg, hgp_px_if, hgp_res_if and hgp_geom.
//
//  channel  | direction | handshake     | payload
//  i_px     | in        | valid / ready | pixel_x, pixel_y
//  o_res    | out       | valid / ready | hit, hex_col, hex_row, local_x, local_y
//  i_cfg_*  | in        | write enable  | register index, data
//
// One query enters per cycle unless a stalled output has backed up the pipe.
// The pipe depth is set by the four parallel 14-bit dividers, which retire
// one quotient bit per stage. A stalled output holds its result; stages
// behind it keep filling empty slots, so bubbles close up. Reset is
// synchronous, active low, and clears the valid bits and the registers to
// their reset values. Derived geometry is registered from the config registers.
`timescale 1ns / 1ps
`default_nettype none
module hex_grid_pixel_to_cell (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    hgp_px_if.sink                               i_px,
    hgp_res_if.source                            o_res,
    input  wire logic                            i_cfg_we,
    input  wire logic [hgp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [hgp_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import hgp_pkg::*;

    localparam int NPIPE = DIV_BITS + 2;   // prep, divider steps, products
    localparam int LAST = NPIPE - 1;

    t_geom geom;

    hgp_geom u_geom (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_geom     (geom)
    );

    logic [NPIPE-1:0] r_vld;
    t_item            r_pipe [NPIPE];
    t_item            n_pipe [NPIPE];
    logic [NPIPE-1:0] adv;
    logic             r_out_vld;
    t_res             r_out, n_out;
    logic             adv_out;

    // A stage moves when it is empty or its successor moves.
    always_comb begin
        adv_out = !r_out_vld || o_res.ready;
        adv[LAST] = !r_vld[LAST] || adv_out;
        for (int i = LAST - 1; i >= 0; i--) begin
            adv[i] = !r_vld[i] || adv[i+1];
        end
    end

    assign i_px.ready = adv[0];

    // Stage 0: map-relative coordinates and the map rectangle test.
    logic signed [16:0] lx_full, ly_full, lxs_full;
    always_comb begin
        lx_full  = 17'(i_px.pixel_x) - $signed({7'd0, geom.left});
        ly_full  = 17'(i_px.pixel_y) - $signed({7'd0, geom.top});
        lxs_full = lx_full - $signed({10'd0, geom.half});

        n_pipe[0] = '0;
        n_pipe[0].raw_x = i_px.pixel_x;
        n_pipe[0].raw_y = i_px.pixel_y;
        n_pipe[0].inmap = geom.ok && !lx_full[16] && !ly_full[16]
            && (17'(i_px.pixel_x) < $signed({1'b0, geom.x_end}))
            && (17'(i_px.pixel_y) < $signed({1'b0, geom.y_end}));
        n_pipe[0].lx = lx_full[DIV_BITS-1:0];
        n_pipe[0].ly = ly_full[DIV_BITS-1:0];
        n_pipe[0].dy = '{rem: 7'd0, quo: ly_full[DIV_BITS-1:0]};
        n_pipe[0].dh = '{rem: 7'd0, quo: lx_full[DIV_BITS-1:0]};
        n_pipe[0].df0 = '{rem: 7'd0, quo: lx_full[DIV_BITS-1:0]};
        n_pipe[0].df1 = '{rem: 7'd0,
                          quo: lxs_full[16] ? '0 : lxs_full[DIV_BITS-1:0]};
    end

    // Stages 1 to DIV_BITS: one quotient bit per divider per stage.
    for (genvar g = 1; g <= DIV_BITS; g++) begin : g_div
        always_comb begin
            n_pipe[g]     = r_pipe[g-1];
            n_pipe[g].dy  = div_step(r_pipe[g-1].dy, geom.rowstep);
            n_pipe[g].dh  = div_step(r_pipe[g-1].dh, geom.half);
            n_pipe[g].df0 = div_step(r_pipe[g-1].df0, geom.hstep);
            n_pipe[g].df1 = div_step(r_pipe[g-1].df1, geom.hstep);
        end
    end

    // Last pipe stage: triangle test products of the sloped band.
    logic [13:0] ty, tx;
    always_comb begin
        n_pipe[LAST] = r_pipe[LAST-1];
        ty = {7'd0, r_pipe[LAST-1].dy.rem} * {7'd0, geom.half};
        tx = {7'd0, r_pipe[LAST-1].dh.rem} * {7'd0, geom.slope};
        n_pipe[LAST].sloped = r_pipe[LAST-1].dy.rem < geom.slope;
        n_pipe[LAST].lt_a = $signed({1'b0, ty}) < ($signed({3'b000, geom.ta})
                            - $signed({1'b0, tx}));
        n_pipe[LAST].lt_b = ty < tx;
    end

    // Output stage: neighbor choice, grid bounds and result fields.
    logic signed [15:0] xs, ys;
    logic               y_odd;
    t_item              it;
    always_comb begin
        it    = r_pipe[LAST];
        ys    = 16'(it.dy.quo);
        y_odd = it.dy.quo[0];
        if (it.sloped) begin
            xs = 16'(it.dh.quo);
            unique case (t_par'({y_odd, it.dh.quo[0]}))
                PAR_XE_YE: begin
                    if (it.lt_a) begin
                        xs = xs - 16'sd1;
                        ys = ys - 16'sd1;
                    end
                end
                PAR_XO_YE: begin
                    if (it.lt_b) ys = ys - 16'sd1;
                end
                PAR_XE_YO: begin
                    if (it.lt_b) begin
                        xs = xs + 16'sd1;
                        ys = ys - 16'sd1;
                    end
                    xs = xs - 16'sd1;
                end
                PAR_XO_YO: begin
                    if (it.lt_a) ys = ys - 16'sd1;
                end
                default: ;
            endcase
            if (!xs[15]) xs = xs >>> 1;
        end else begin
            xs = y_odd ? 16'(it.df1.quo) : 16'(it.df0.quo);
        end

        n_out.hit = it.inmap && !xs[15] && !ys[15]
                    && (xs < $signed({9'd0, geom.gw})) && (ys < $signed({9'd0, geom.gh}));
        n_out.hex_col = n_out.hit ? xs[7:0] : -8'sd1;
        n_out.hex_row = n_out.hit ? ys[7:0] : -8'sd1;
        if (!it.inmap) begin
            n_out.local_x = it.raw_x;
        end else if (!it.sloped && y_odd) begin
            n_out.local_x = 16'(it.lx) - 16'(geom.half);
        end else begin
            n_out.local_x = 16'(it.lx);
        end
        n_out.local_y = it.inmap ? 16'(it.ly) : it.raw_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (adv[0]) r_vld[0] <= i_px.valid;
            for (int i = 1; i < NPIPE; i++) begin
                if (adv[i]) r_vld[i] <= r_vld[i-1];
            end
            if (adv_out) r_out_vld <= r_vld[LAST];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NPIPE; i++) begin
            if (adv[i]) r_pipe[i] <= n_pipe[i];
        end
        if (adv_out) r_out <= n_out;
    end

    assign o_res.valid   = r_out_vld;
    assign o_res.hit     = r_out.hit;
    assign o_res.hex_col = r_out.hex_col;
    assign o_res.hex_row = r_out.hex_row;
    assign o_res.local_x = r_out.local_x;
    assign o_res.local_y = r_out.local_y;

`ifndef ASSERT_OFF
    a_hold_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[LAST] && r_out_vld && !o_res.ready |=> r_vld[LAST])
        else $error("last pipe stage dropped a transaction under stall");
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_px.valid && i_px.ready |=> r_vld[0])
        else $error("accepted transaction did not enter the pipe");
    a_hit_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.hit |-> !o_res.hex_col[7] && !o_res.hex_row[7])
        else $error("hit with negative cell index");
    a_miss_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.hit |-> o_res.hex_col == -8'sd1 && o_res.hex_row == -8'sd1)
        else $error("miss without cell index of minus one");
`endif

endmodule
`default_nettype wire
